// ===== rtl/mmd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmd_pkg
// Shared types and constants for the trapped MOV instruction decoder.
// ----------------------------------------------------------------------------
package mmd_pkg;

    // Longest instruction accepted, in bytes
    localparam int MAX_LEN   = 15;
    // Immediate bytes of the C7 form
    localparam int IMM_BYTES = 4;

    // Result queue between decoder and output side
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FETCH_ERR = 2'd1;
    localparam logic [1:0] ST_UNSUPP    = 2'd2;
    localparam logic [1:0] ST_DIR_ERR   = 2'd3;

    // One instruction byte transfer
    typedef struct packed {
        logic [7:0] inst_byte;
        logic       fetch_failed;
        logic       expect_write;
    } t_in_item;

    // One decode result
    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  length;
        logic [3:0]  access_bytes;
        logic [3:0]  reg_index;
        logic        is_store;
        logic        has_imm;
        logic [31:0] imm_value;
    } t_out_item;

endpackage
`default_nettype wire

// ===== rtl/mmd_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmd_front
// Byte-serial decoder: walks prefix, opcode, ModRM, SIB and, for C7 only,
// displacement and immediate bytes; emits one result on end or failure.
// ----------------------------------------------------------------------------
module mmd_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  mmd_pkg::t_in_item      i_item,
    output logic                   o_push,
    output mmd_pkg::t_out_item     o_result
);

    // Decode phases
    localparam logic [2:0] PH_OPCODE = 3'd0;
    localparam logic [2:0] PH_MOVZX  = 3'd1;
    localparam logic [2:0] PH_MODRM  = 3'd2;
    localparam logic [2:0] PH_SIB    = 3'd3;
    localparam logic [2:0] PH_SKIP   = 3'd4;
    localparam logic [2:0] PH_IMM    = 3'd5;

    // Opcodes
    localparam logic [7:0] OP_TWO_BYTE = 8'h0F;
    localparam logic [7:0] OP_MOVZX_B  = 8'hB6;
    localparam logic [7:0] OP_MOVZX_W  = 8'hB7;
    localparam logic [7:0] OP_MOVB_ST  = 8'h88;
    localparam logic [7:0] OP_MOV_ST   = 8'h89;
    localparam logic [7:0] OP_MOV_LD   = 8'h8B;
    localparam logic [7:0] OP_MOV_IMM  = 8'hC7;
    localparam logic [7:0] OP_LD_ACC   = 8'hA1;
    localparam logic [7:0] OP_ST_ACC   = 8'hA3;
    localparam logic [3:0] ACC_SLOT    = 4'd15;

    logic [2:0]  r_phase,       n_phase;
    logic        r_rex_wide,    n_rex_wide;
    logic        r_rex_reg_ext, n_rex_reg_ext;
    logic        r_imm_pending, n_imm_pending;
    logic        r_store_flag,  n_store_flag;
    logic [3:0]  r_size_hold,   n_size_hold;
    logic [3:0]  r_bytes_seen,  n_bytes_seen;
    logic [2:0]  r_skip_left,   n_skip_left;
    logic [31:0] r_imm_acc,     n_imm_acc;
    logic [2:0]  r_imm_count,   n_imm_count;
    logic [3:0]  r_reg_hold,    n_reg_hold;

    logic [7:0]  b;
    logic [3:0]  seen1;
    logic [3:0]  wide_size;
    logic        fail_en;
    logic [1:0]  fail_code;
    logic        done_en;
    logic [3:0]  done_len;
    logic        addr_en;
    logic [2:0]  disp;
    logic        drop_en;
    logic [4:0]  total;
    logic [4:0]  moffs_total;
    logic [1:0]  mod_f;
    logic [2:0]  reg_f;
    logic [2:0]  rm_f;

    assign b           = i_item.inst_byte;
    assign seen1       = r_bytes_seen + 4'd1;
    assign wide_size   = r_rex_wide ? 4'd8 : 4'd4;
    assign mod_f       = b[7:6];
    assign reg_f       = b[5:3];
    assign rm_f        = b[2:0];
    assign moffs_total = {1'b0, seen1} + 5'd4;

    // Per-byte decode
    always_comb begin
        n_phase       = r_phase;
        n_rex_wide    = r_rex_wide;
        n_rex_reg_ext = r_rex_reg_ext;
        n_imm_pending = r_imm_pending;
        n_store_flag  = r_store_flag;
        n_size_hold   = r_size_hold;
        n_bytes_seen  = r_bytes_seen;
        n_skip_left   = r_skip_left;
        n_imm_acc     = r_imm_acc;
        n_imm_count   = r_imm_count;
        n_reg_hold    = r_reg_hold;
        fail_en       = 1'b0;
        fail_code     = mmd_pkg::ST_OK;
        done_en       = 1'b0;
        done_len      = 4'd0;
        addr_en       = 1'b0;
        disp          = 3'd0;
        drop_en       = 1'b0;
        total         = 5'd0;
        o_push        = 1'b0;
        o_result      = '0;

        if (i_accept) begin
            if (i_item.fetch_failed ||
                (r_bytes_seen >= 4'(mmd_pkg::MAX_LEN))) begin
                fail_en   = 1'b1;
                fail_code = mmd_pkg::ST_FETCH_ERR;
            end else begin
                n_bytes_seen = seen1;
                case (r_phase)
                    PH_OPCODE: begin
                        if (b[7:4] == 4'h4) begin
                            // REX prefix; X is not supported
                            if (b[1]) begin
                                fail_en   = 1'b1;
                                fail_code = mmd_pkg::ST_UNSUPP;
                            end else begin
                                if (b[3]) n_rex_wide    = 1'b1;
                                if (b[2]) n_rex_reg_ext = 1'b1;
                            end
                        end else begin
                            case (b)
                                OP_TWO_BYTE: n_phase = PH_MOVZX;
                                OP_MOVB_ST: begin
                                    n_size_hold  = 4'd1;
                                    n_store_flag = 1'b1;
                                    n_phase      = PH_MODRM;
                                end
                                OP_MOV_ST: begin
                                    n_size_hold  = wide_size;
                                    n_store_flag = 1'b1;
                                    n_phase      = PH_MODRM;
                                end
                                OP_MOV_LD: begin
                                    n_size_hold = wide_size;
                                    n_phase     = PH_MODRM;
                                end
                                OP_MOV_IMM: begin
                                    n_size_hold   = wide_size;
                                    n_store_flag  = 1'b1;
                                    n_imm_pending = 1'b1;
                                    n_phase       = PH_MODRM;
                                end
                                OP_LD_ACC, OP_ST_ACC: begin
                                    // moffs: address bytes counted, not consumed
                                    if (moffs_total > 5'(mmd_pkg::MAX_LEN)) begin
                                        fail_en   = 1'b1;
                                        fail_code = mmd_pkg::ST_FETCH_ERR;
                                    end else begin
                                        n_size_hold  = wide_size;
                                        n_store_flag = (b == OP_ST_ACC);
                                        n_reg_hold   = ACC_SLOT;
                                        done_en      = 1'b1;
                                        done_len     = moffs_total[3:0];
                                    end
                                end
                                default: begin
                                    fail_en   = 1'b1;
                                    fail_code = mmd_pkg::ST_UNSUPP;
                                end
                            endcase
                        end
                    end
                    PH_MOVZX: begin
                        if (b == OP_MOVZX_B) begin
                            n_size_hold = 4'd1;
                            n_phase     = PH_MODRM;
                        end else if (b == OP_MOVZX_W) begin
                            n_size_hold = 4'd2;
                            n_phase     = PH_MODRM;
                        end else begin
                            fail_en   = 1'b1;
                            fail_code = mmd_pkg::ST_UNSUPP;
                        end
                    end
                    PH_MODRM: begin
                        n_reg_hold = r_rex_reg_ext ? (4'd7 - {1'b0, reg_f})
                                                   : (4'd15 - {1'b0, reg_f});
                        if ((mod_f == 2'd3) || ((mod_f != 2'd0) && (rm_f == 3'd4))) begin
                            fail_en   = 1'b1;
                            fail_code = mmd_pkg::ST_UNSUPP;
                        end else if (rm_f == 3'd4) begin
                            n_phase = PH_SIB;
                        end else begin
                            addr_en = 1'b1;
                            if (mod_f == 2'd0)
                                disp = (rm_f == 3'd5) ? 3'd4 : 3'd0;
                            else
                                disp = (mod_f == 2'd1) ? 3'd1 : 3'd4;
                        end
                    end
                    PH_SIB: begin
                        addr_en = 1'b1;
                        disp    = (b[2:0] == 3'd5) ? 3'd4 : 3'd0;
                    end
                    PH_SKIP: begin
                        if ((r_skip_left == 3'd0) || (r_skip_left == 3'd1)) begin
                            n_skip_left = 3'd0;
                            n_phase     = PH_IMM;
                        end else begin
                            n_skip_left = r_skip_left - 3'd1;
                        end
                    end
                    PH_IMM: begin
                        n_imm_acc   = r_imm_acc | (32'(b) << {r_imm_count[1:0], 3'b000});
                        n_imm_count = r_imm_count + 3'd1;
                        if (n_imm_count >= 3'(mmd_pkg::IMM_BYTES)) begin
                            done_en  = 1'b1;
                            done_len = seen1;
                        end
                    end
                    default: drop_en = 1'b1;
                endcase

                // Addressing bytes done: register check, length check
                if (addr_en) begin
                    total = {1'b0, seen1} + {2'b00, disp}
                          + (r_imm_pending ? 5'(mmd_pkg::IMM_BYTES) : 5'd0);
                    if (!r_rex_reg_ext && (n_reg_hold == 4'd11)) begin
                        fail_en   = 1'b1;
                        fail_code = mmd_pkg::ST_UNSUPP;
                    end else if (total > 5'(mmd_pkg::MAX_LEN)) begin
                        fail_en   = 1'b1;
                        fail_code = mmd_pkg::ST_FETCH_ERR;
                    end else if (!r_imm_pending) begin
                        done_en  = 1'b1;
                        done_len = 4'({1'b0, seen1} + {2'b00, disp});
                    end else if (disp != 3'd0) begin
                        n_skip_left = disp;
                        n_phase     = PH_SKIP;
                    end else begin
                        n_phase = PH_IMM;
                    end
                end
            end

            // Completion: direction check, then result
            if (done_en && !fail_en && (n_store_flag != i_item.expect_write)) begin
                fail_en   = 1'b1;
                fail_code = mmd_pkg::ST_DIR_ERR;
            end
            if (fail_en) begin
                o_push          = 1'b1;
                o_result.status = fail_code;
            end else if (done_en) begin
                o_push                = 1'b1;
                o_result.status       = mmd_pkg::ST_OK;
                o_result.length       = done_len;
                o_result.access_bytes = n_size_hold;
                o_result.reg_index    = n_reg_hold;
                o_result.is_store     = n_store_flag;
                o_result.has_imm      = n_imm_pending;
                o_result.imm_value    = n_imm_pending ? n_imm_acc : 32'd0;
            end

            // Back to idle after a result or a dropped byte
            if (fail_en || done_en || drop_en) begin
                n_phase       = PH_OPCODE;
                n_rex_wide    = 1'b0;
                n_rex_reg_ext = 1'b0;
                n_imm_pending = 1'b0;
                n_store_flag  = 1'b0;
                n_size_hold   = 4'd0;
                n_bytes_seen  = 4'd0;
                n_skip_left   = 3'd0;
                n_imm_acc     = 32'd0;
                n_imm_count   = 3'd0;
                n_reg_hold    = 4'd0;
            end
        end
    end

    // Decode state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_OPCODE;
            r_rex_wide    <= 1'b0;
            r_rex_reg_ext <= 1'b0;
            r_imm_pending <= 1'b0;
            r_store_flag  <= 1'b0;
            r_size_hold   <= 4'd0;
            r_bytes_seen  <= 4'd0;
            r_skip_left   <= 3'd0;
            r_imm_acc     <= 32'd0;
            r_imm_count   <= 3'd0;
            r_reg_hold    <= 4'd0;
        end else begin
            r_phase       <= n_phase;
            r_rex_wide    <= n_rex_wide;
            r_rex_reg_ext <= n_rex_reg_ext;
            r_imm_pending <= n_imm_pending;
            r_store_flag  <= n_store_flag;
            r_size_hold   <= n_size_hold;
            r_bytes_seen  <= n_bytes_seen;
            r_skip_left   <= n_skip_left;
            r_imm_acc     <= n_imm_acc;
            r_imm_count   <= n_imm_count;
            r_reg_hold    <= n_reg_hold;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/mmd_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmd_queue
// Small result queue; the head entry drives the output channel directly.
// ----------------------------------------------------------------------------
module mmd_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  mmd_pkg::t_out_item     i_item,
    output logic                   o_full,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output mmd_pkg::t_out_item     o_item
);

    mmd_pkg::t_out_item r_mem [mmd_pkg::Q_DEPTH];

    logic [mmd_pkg::Q_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [mmd_pkg::Q_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [mmd_pkg::Q_CW-1:0] r_count,  n_count;
    logic                     pop;

    assign o_full  = (r_count == mmd_pkg::Q_CW'(mmd_pkg::Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign pop     = o_valid && !i_stall;

    // Pointer and occupancy update
    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = pop    ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !pop)
            n_count = r_count + 1'b1;
        else if (!i_push && pop)
            n_count = r_count - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push)
            r_mem[r_wr_ptr] <= i_item;
    end

endmodule
`default_nettype wire

// ===== rtl/mmio_mov_instruction_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmio_mov_instruction_decoder
// Length and operand decoder for one trapped x86 memory-move instruction,
// fed one byte per transfer, with a result queue on the output side.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+--------------------
//  in       | input     | i_in_valid / o_in_stall | i_in_item (t_in_item)
//  out      | output    | o_out_valid/ i_out_stall| o_out_item (t_out_item)
//
//  One byte is decoded per cycle while the queue has room; the decode state is
//  a single register set. A result is written into a 4-entry queue and shows
//  on the output from the queue head. Input stalls only while the queue holds
//  4 results waiting to be taken. Synchronous active-low reset returns the
//  decoder to the opcode phase and empties the queue.
// ----------------------------------------------------------------------------
module mmio_mov_instruction_decoder (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  mmd_pkg::t_in_item      i_in_item,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output mmd_pkg::t_out_item     o_out_item
);

    logic               q_full;
    logic               accept;
    logic               push;
    mmd_pkg::t_out_item result;

    assign o_in_stall = q_full;
    assign accept     = i_in_valid && !q_full;

    // Decoder
    mmd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_in_item),
        .o_push   (push),
        .o_result (result)
    );

    // Result queue and output side
    mmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (result),
        .o_full  (q_full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_item  (o_out_item)
    );

endmodule
`default_nettype wire

// ===== rtl/mmd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmd_checker
// Port-level checks on the decoder's result channel.
// ----------------------------------------------------------------------------
module mmd_checker (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              o_in_stall,
    input wire logic              o_out_valid,
    input wire logic              i_out_stall,
    input mmd_pkg::t_out_item     o_out_item
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_item)))
        else $error("stalled result changed");

    // Error results carry nothing but status
    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.status != mmd_pkg::ST_OK)) |->
        ((o_out_item.length == 4'd0) && (o_out_item.access_bytes == 4'd0) &&
         (o_out_item.reg_index == 4'd0) && !o_out_item.is_store &&
         !o_out_item.has_imm && (o_out_item.imm_value == 32'd0)))
        else $error("error result with nonzero fields");

    // Good results have a legal size and a nonzero length
    a_ok_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.status == mmd_pkg::ST_OK)) |->
        (((o_out_item.access_bytes == 4'd1) || (o_out_item.access_bytes == 4'd2) ||
          (o_out_item.access_bytes == 4'd4) || (o_out_item.access_bytes == 4'd8)) &&
         (o_out_item.length != 4'd0)))
        else $error("bad access size or length");

    // Immediate only with the immediate form, which is always a store
    a_imm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.has_imm) |-> o_out_item.is_store)
        else $error("immediate on a non-store");

    // Nothing pending on the first cycle out of reset
    a_reset: assert property (@(posedge i_clk)
        (i_rst_n && $past(!i_rst_n)) |-> (!o_out_valid && !o_in_stall))
        else $error("queue not empty after reset");

endmodule

bind mmio_mov_instruction_decoder mmd_checker u_mmd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
`default_nettype wire

// ===== tb/tb_mmio_mov_instruction_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mmio_mov_instruction_decoder
// Self-checking bench for the trapped MOV decoder. Instruction bytes are fed
// through the input channel in bursts. A byte-level model of the decoder
// predicts each result, and every output transfer is compared field by field
// against the oldest prediction. A short directed set covers the special
// encodings. Random traffic follows: mostly well-formed MOV forms, with some
// broken sequences and plain noise. Output stalls are heavy enough to fill
// the result queue.
// ----------------------------------------------------------------------------
module tb_mmio_mov_instruction_decoder;

    localparam int CYCLE_LIMIT = 400000;

    // Opcode bytes recognized by the decoder
    localparam logic [7:0] OP_ESCAPE     = 8'h0F;
    localparam logic [7:0] OP_MOVZX_B    = 8'hB6;
    localparam logic [7:0] OP_MOVZX_W    = 8'hB7;
    localparam logic [7:0] OP_MOVB_STORE = 8'h88;
    localparam logic [7:0] OP_MOV_STORE  = 8'h89;
    localparam logic [7:0] OP_MOV_LOAD   = 8'h8B;
    localparam logic [7:0] OP_MOV_IMM    = 8'hC7;
    localparam logic [7:0] OP_LOAD_ACC   = 8'hA1;
    localparam logic [7:0] OP_STORE_ACC  = 8'hA3;

    // Register slots: accumulator, and reg field 4 when REX.R is clear
    localparam logic [3:0] ACC_SLOT   = 4'd15;
    localparam logic [3:0] REG4_SLOT  = 4'd11;

    typedef enum logic [2:0] {
        PH_OPCODE, PH_MOVZX2, PH_MODRM, PH_SIB, PH_DISP, PH_IMM
    } t_dec_phase;

    typedef logic [7:0] t_byte_q [$];

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    mmd_pkg::t_in_item   i_in_item = '0;
    logic                i_out_stall = 1'b0;
    logic                o_in_stall;
    logic                o_out_valid;
    mmd_pkg::t_out_item  o_out_item;

    // Decoder model state
    t_dec_phase  dec_phase = PH_OPCODE;
    logic        wide_op = 1'b0;
    logic        reg_ext = 1'b0;
    logic        imm_wanted = 1'b0;
    logic        writes_mem = 1'b0;
    logic [3:0]  op_size = '0;
    logic [3:0]  byte_count = '0;
    logic [3:0]  reg_slot = '0;
    logic [2:0]  disp_left = '0;
    logic [2:0]  imm_got = '0;
    logic [31:0] imm_word = '0;

    mmd_pkg::t_out_item pending_decodes [$];
    int        mismatch_count = 0;
    int        cycle_count = 0;
    int        bytes_sent = 0;

    // Traffic shaping knobs
    int gap_max = 0;
    int burst_max = 8;
    int burst_left = 0;
    int stall_pct = 0;
    int stall_run = 0;
    logic stall_hold = 1'b0;

    mmio_mov_instruction_decoder u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Decoder model
    // ------------------------------------------------------------------------
    function automatic void clear_decoder();
        dec_phase  = PH_OPCODE;
        wide_op    = 1'b0;
        reg_ext    = 1'b0;
        imm_wanted = 1'b0;
        writes_mem = 1'b0;
        op_size    = '0;
        byte_count = '0;
        reg_slot   = '0;
        disp_left  = '0;
        imm_got    = '0;
        imm_word   = '0;
    endfunction

    // Error result: only status is set
    function automatic mmd_pkg::t_out_item error_result(input logic [1:0] st);
        mmd_pkg::t_out_item r;
        r = '0;
        r.status = st;
        clear_decoder();
        return r;
    endfunction

    function automatic mmd_pkg::t_out_item finish_insn(input logic expect_write,
                                                       input int len);
        mmd_pkg::t_out_item r;
        r = '0;
        if (writes_mem != expect_write)
            return error_result(mmd_pkg::ST_DIR_ERR);
        r.status       = mmd_pkg::ST_OK;
        r.length       = 4'(len);
        r.access_bytes = op_size;
        r.reg_index    = reg_slot;
        r.is_store     = writes_mem;
        r.has_imm      = imm_wanted;
        r.imm_value    = imm_wanted ? imm_word : '0;
        clear_decoder();
        return r;
    endfunction

    // ModRM/SIB done: check register and length, then finish or go for imm
    function automatic bit addressing_done(input logic expect_write, input int disp,
                                           output mmd_pkg::t_out_item r);
        int total;
        r = '0;
        if (!reg_ext && reg_slot == REG4_SLOT) begin
            r = error_result(mmd_pkg::ST_UNSUPP);
            return 1'b1;
        end
        total = byte_count + disp + (imm_wanted ? mmd_pkg::IMM_BYTES : 0);
        if (total > mmd_pkg::MAX_LEN) begin
            r = error_result(mmd_pkg::ST_FETCH_ERR);
            return 1'b1;
        end
        if (!imm_wanted) begin
            r = finish_insn(expect_write, byte_count + disp);
            return 1'b1;
        end
        if (disp > 0) begin
            disp_left = 3'(disp);
            dec_phase = PH_DISP;
        end else begin
            dec_phase = PH_IMM;
        end
        return 1'b0;
    endfunction

    // Advance the model by one byte; returns 1 when a result is due
    function automatic bit decode_byte(input mmd_pkg::t_in_item it,
                                       output mmd_pkg::t_out_item r);
        logic [7:0] b;
        logic [1:0] md;
        logic [2:0] rg;
        logic [2:0] rm;
        int         disp;
        r = '0;
        if (it.fetch_failed || byte_count >= mmd_pkg::MAX_LEN) begin
            r = error_result(mmd_pkg::ST_FETCH_ERR);
            return 1'b1;
        end
        byte_count++;
        b = it.inst_byte;
        case (dec_phase)
            PH_OPCODE: begin
                // REX prefix; X bit is not supported
                if (b[7:4] == 4'h4) begin
                    if (b[1]) begin
                        r = error_result(mmd_pkg::ST_UNSUPP);
                        return 1'b1;
                    end
                    if (b[3]) wide_op = 1'b1;
                    if (b[2]) reg_ext = 1'b1;
                    return 1'b0;
                end
                case (b)
                    OP_ESCAPE: begin
                        dec_phase = PH_MOVZX2;
                        return 1'b0;
                    end
                    OP_MOVB_STORE: begin
                        op_size = 4'd1;
                        writes_mem = 1'b1;
                    end
                    OP_MOV_STORE: begin
                        op_size = wide_op ? 4'd8 : 4'd4;
                        writes_mem = 1'b1;
                    end
                    OP_MOV_LOAD: begin
                        op_size = wide_op ? 4'd8 : 4'd4;
                    end
                    OP_MOV_IMM: begin
                        op_size = wide_op ? 4'd8 : 4'd4;
                        writes_mem = 1'b1;
                        imm_wanted = 1'b1;
                    end
                    OP_LOAD_ACC, OP_STORE_ACC: begin
                        // moffs: address bytes are counted, not consumed
                        if (byte_count + 4 > mmd_pkg::MAX_LEN) begin
                            r = error_result(mmd_pkg::ST_FETCH_ERR);
                            return 1'b1;
                        end
                        op_size = wide_op ? 4'd8 : 4'd4;
                        writes_mem = (b == OP_STORE_ACC);
                        reg_slot = ACC_SLOT;
                        r = finish_insn(it.expect_write, byte_count + 4);
                        return 1'b1;
                    end
                    default: begin
                        r = error_result(mmd_pkg::ST_UNSUPP);
                        return 1'b1;
                    end
                endcase
                dec_phase = PH_MODRM;
                return 1'b0;
            end
            PH_MOVZX2: begin
                if (b == OP_MOVZX_B) begin
                    op_size = 4'd1;
                end else if (b == OP_MOVZX_W) begin
                    op_size = 4'd2;
                end else begin
                    r = error_result(mmd_pkg::ST_UNSUPP);
                    return 1'b1;
                end
                dec_phase = PH_MODRM;
                return 1'b0;
            end
            PH_MODRM: begin
                md = b[7:6];
                rg = b[5:3];
                rm = b[2:0];
                reg_slot = reg_ext ? (4'd7 - rg) : (4'd15 - rg);
                if (md == 2'd3 || (md != 2'd0 && rm == 3'd4)) begin
                    r = error_result(mmd_pkg::ST_UNSUPP);
                    return 1'b1;
                end
                if (md == 2'd0 && rm == 3'd4) begin
                    dec_phase = PH_SIB;
                    return 1'b0;
                end
                if (md == 2'd0)
                    disp = (rm == 3'd5) ? 4 : 0;
                else
                    disp = (md == 2'd1) ? 1 : 4;
                return addressing_done(it.expect_write, disp, r);
            end
            PH_SIB: begin
                return addressing_done(it.expect_write, (b[2:0] == 3'd5) ? 4 : 0, r);
            end
            PH_DISP: begin
                if (disp_left > 0) disp_left--;
                if (disp_left == 0) dec_phase = PH_IMM;
                return 1'b0;
            end
            PH_IMM: begin
                imm_word |= 32'(b) << (8 * imm_got[1:0]);
                imm_got++;
                if (imm_got >= mmd_pkg::IMM_BYTES) begin
                    r = finish_insn(it.expect_write, byte_count);
                    return 1'b1;
                end
                return 1'b0;
            end
            default: begin
                clear_decoder();
                return 1'b0;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------
    function automatic void check_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            mismatch_count++;
            $display("%0t: %s differs, expected %0h, actual %0h",
                     $time, field, want, got);
        end
    endfunction

    // Compare output transfers, then predict from input transfers
    always @(posedge i_clk) begin
        mmd_pkg::t_out_item predicted;
        mmd_pkg::t_out_item oldest;
        if (!i_rst_n) begin
            clear_decoder();
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_decodes.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: result with none expected, expected nothing, actual %p",
                             $time, o_out_item);
                end else begin
                    oldest = pending_decodes.pop_front();
                    check_field("status", oldest.status, o_out_item.status);
                    check_field("length", oldest.length, o_out_item.length);
                    check_field("access_bytes", oldest.access_bytes,
                                o_out_item.access_bytes);
                    check_field("reg_index", oldest.reg_index, o_out_item.reg_index);
                    check_field("is_store", oldest.is_store, o_out_item.is_store);
                    check_field("has_imm", oldest.has_imm, o_out_item.has_imm);
                    check_field("imm_value", oldest.imm_value, o_out_item.imm_value);
                end
            end
            if (i_in_valid && !o_in_stall) begin
                if (decode_byte(i_in_item, predicted))
                    pending_decodes.push_back(predicted);
            end
        end
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     pending_decodes.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // Output side stalls in runs of random length
    always @(negedge i_clk) begin
        if (stall_run == 0) begin
            stall_hold = ($urandom_range(0, 99) < stall_pct);
            stall_run = $urandom_range(1, 8);
        end
        stall_run--;
        i_out_stall <= stall_hold;
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    // Entered and left just after a falling edge; holds the byte until transfer
    task automatic send_byte(input mmd_pkg::t_in_item it);
        if (gap_max > 0 && burst_left <= 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, gap_max)) @(negedge i_clk);
            burst_left = $urandom_range(1, burst_max);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic put(input logic [7:0] b, input logic ff, input logic ew);
        mmd_pkg::t_in_item it;
        it.inst_byte    = b;
        it.fetch_failed = ff;
        it.expect_write = ew;
        send_byte(it);
    endtask

    // Random MOV form, optionally prefixed; stores tells its direction
    function automatic t_byte_q build_mov(output logic stores);
        t_byte_q    q;
        int         n_rex;
        int         form;
        int         md;
        int         disp;
        logic [7:0] rex;
        logic [7:0] modrm;
        logic [7:0] sib;
        q = {};
        if ($urandom_range(0, 19) == 0)
            n_rex = $urandom_range(4, 15);
        else
            n_rex = $urandom_range(0, 1) ? 0 : $urandom_range(1, 2);
        repeat (n_rex) begin
            rex = {4'h4, 4'($urandom_range(0, 15))};
            if ($urandom_range(0, 9) != 0) rex[1] = 1'b0;
            q.push_back(rex);
        end
        form = $urandom_range(0, 7);
        stores = (form inside {2, 3, 5, 7});
        case (form)
            0: begin
                q.push_back(OP_ESCAPE);
                q.push_back(OP_MOVZX_B);
            end
            1: begin
                q.push_back(OP_ESCAPE);
                q.push_back(OP_MOVZX_W);
            end
            2: q.push_back(OP_MOVB_STORE);
            3: q.push_back(OP_MOV_STORE);
            4: q.push_back(OP_MOV_LOAD);
            5: q.push_back(OP_MOV_IMM);
            6: begin
                q.push_back(OP_LOAD_ACC);
                return q;
            end
            default: begin
                q.push_back(OP_STORE_ACC);
                return q;
            end
        endcase
        md = ($urandom_range(0, 19) == 0) ? 3 : $urandom_range(0, 2);
        modrm = {2'(md), 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7))};
        q.push_back(modrm);
        if (md == 0 && modrm[2:0] == 3'd4) begin
            sib = 8'($urandom);
            q.push_back(sib);
            disp = (sib[2:0] == 3'd5) ? 4 : 0;
        end else if (md == 0) begin
            disp = (modrm[2:0] == 3'd5) ? 4 : 0;
        end else begin
            disp = (md == 1) ? 1 : 4;
        end
        // displacement is only consumed ahead of an immediate
        if (form == 5) begin
            repeat (disp) q.push_back(8'($urandom));
            repeat (mmd_pkg::IMM_BYTES)
                q.push_back(($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom));
        end
        return q;
    endfunction

    task automatic send_mov();
        t_byte_q            q;
        logic               stores;
        mmd_pkg::t_in_item  it;
        q = build_mov(stores);
        foreach (q[k]) begin
            it.inst_byte    = q[k];
            it.fetch_failed = ($urandom_range(0, 99) == 0);
            // direction is only looked at on the closing byte
            if (k == q.size() - 1)
                it.expect_write = ($urandom_range(0, 9) == 0) ? !stores : stores;
            else
                it.expect_write = 1'($urandom);
            send_byte(it);
        end
    endtask

    task automatic run_mov_stream(input int n_bytes);
        int stop_at;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) send_mov();
    endtask

    // Special encodings, one after another
    task automatic test_directed();
        gap_max = 2;
        burst_max = 4;
        stall_pct = 20;
        put(8'hFF, 1'b1, 1'b0);                    // fetch failure
        put(8'h00, 1'b0, 1'b0);                    // unknown opcode
        put(8'h4A, 1'b0, 1'b0);                    // REX with X
        put(OP_MOV_STORE, 1'b0, 1'b0);             // store, plain ModRM
        put(8'h00, 1'b0, 1'b1);
        put(8'h48, 1'b0, 1'b1);                    // wide load, rip-relative
        put(OP_MOV_LOAD, 1'b0, 1'b1);
        put(8'h05, 1'b0, 1'b0);
        put(OP_ESCAPE, 1'b0, 1'b1);                // movzx word
        put(OP_MOVZX_W, 1'b0, 1'b1);
        put(8'h00, 1'b0, 1'b0);
        put(OP_ESCAPE, 1'b0, 1'b0);                // bad second byte
        put(8'h12, 1'b0, 1'b0);
        put(OP_STORE_ACC, 1'b0, 1'b0);             // moffs store, wrong direction
        put(8'h44, 1'b0, 1'b0);                    // imm store, disp8 skipped
        put(OP_MOV_IMM, 1'b0, 1'b0);
        put(8'h45, 1'b0, 1'b0);
        put(8'h7F, 1'b0, 1'b0);
        put(8'h00, 1'b0, 1'b0);
        put(8'h00, 1'b0, 1'b0);
        put(8'h00, 1'b0, 1'b0);
        put(8'h80, 1'b0, 1'b1);
        put(OP_MOV_LOAD, 1'b0, 1'b0);              // register operand
        put(8'hE0, 1'b0, 1'b0);
        put(OP_MOVB_STORE, 1'b0, 1'b1);            // reg field 4 without REX.R
        put(8'h20, 1'b0, 1'b1);
    endtask

    task automatic test_back_to_back();
        gap_max = 0;
        stall_pct = 0;
        run_mov_stream(400);
    endtask

    task automatic test_bursty();
        gap_max = 6;
        burst_max = 12;
        stall_pct = 30;
        run_mov_stream(900);
    endtask

    // Heavy output stalls fill the result queue
    task automatic test_backpressure();
        gap_max = 0;
        stall_pct = 85;
        run_mov_stream(400);
    endtask

    task automatic test_noise();
        mmd_pkg::t_in_item it;
        gap_max = 3;
        burst_max = 6;
        stall_pct = 40;
        repeat (250) begin
            it.inst_byte    = 8'($urandom);
            it.fetch_failed = ($urandom_range(0, 19) == 0);
            it.expect_write = 1'($urandom);
            send_byte(it);
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_back_to_back();
        test_bursty();
        test_backpressure();
        test_noise();
        i_in_valid <= 1'b0;
        stall_pct = 25;
        while (pending_decodes.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && pending_decodes.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/mmd_pkg.sv
rtl/mmd_front.sv
rtl/mmd_queue.sv
rtl/mmio_mov_instruction_decoder.sv
rtl/mmd_checker.sv
tb/tb_mmio_mov_instruction_decoder.sv
